// File: rtl/core/m64c_pkg.sv
// ----------------------------------------------------------------------------
// m64c_pkg
// Shared types, constants and helpers for the MIPS64 integer core step block.
// ----------------------------------------------------------------------------
package m64c_pkg;

  localparam logic [31:0] BootPc    = 32'hA400_0040;
  localparam logic [63:0] BootR11   = 64'hFFFF_FFFF_A400_0040;
  localparam logic [63:0] BootR20   = 64'h0000_0000_0000_0001;
  localparam logic [63:0] BootR22   = 64'h0000_0000_0000_003F;
  localparam logic [63:0] BootR29   = 64'hFFFF_FFFF_A400_1FF0;
  localparam int unsigned NumRegs   = 32;
  localparam int unsigned DivBits   = 32;

  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemLoad  = 2'd1;
  localparam logic [1:0] MemStore = 2'd2;

  localparam logic [1:0] FaultNone    = 2'd0;
  localparam logic [1:0] FaultOpcode  = 2'd1;
  localparam logic [1:0] FaultAlign   = 2'd2;

  typedef struct packed {
    logic [31:0] fetch_pc;
    logic [1:0]  mem_request;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic [63:0] store_data;
    logic [1:0]  fault;
  } result_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] instr_word;
    logic [63:0] load_data;
  } item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic read_regs; // read operands from the register file
    logic execute;   // compute and commit a non-iterative operation
    logic div_start; // start the divider
    logic div_step;  // one divider step
    logic div_done;  // commit divider results
    logic res_load;  // load the result register
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_div;
    logic div_last;
  } stat_t;

  function automatic logic [63:0] sx32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage

// File: rtl/core/m64c_stream_if.sv
// ----------------------------------------------------------------------------
// m64c_stream_if
// Valid/ready channel carrying one payload type.
// ----------------------------------------------------------------------------
interface m64c_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/m64c_ram.sv
// ----------------------------------------------------------------------------
// m64c_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module m64c_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

// File: rtl/core/m64c_ctrl.sv
// ----------------------------------------------------------------------------
// m64c_ctrl
// Sequencer: accept, register read, execute or divide, deliver the result.
// ----------------------------------------------------------------------------
module m64c_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  m64c_pkg::stat_t stat_i,
  output m64c_pkg::ctrl_t ctrl_o
);
  typedef enum logic [2:0] {
    StIdle, StRead, StExec, StDiv, StDivEnd, StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.capture   = (state_q == StIdle) && in_valid_i;
    ctrl_o.read_regs = (state_q == StRead);
    ctrl_o.execute   = (state_q == StExec) && !stat_i.is_div;
    ctrl_o.div_start = (state_q == StExec) && stat_i.is_div;
    ctrl_o.div_step  = (state_q == StDiv);
    ctrl_o.div_done  = (state_q == StDivEnd);
    ctrl_o.res_load  = ctrl_o.execute || ctrl_o.div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StRead;
        StRead: state_q <= StExec;
        StExec: begin
          if (stat_i.is_div) begin
            state_q <= StDiv;
          end else begin
            state_q     <= StOut;
            out_valid_q <= 1'b1;
          end
        end
        StDiv: if (stat_i.div_last) state_q <= StDivEnd;
        StDivEnd: begin
          state_q     <= StOut;
          out_valid_q <= 1'b1;
        end
        StOut: begin
          if (out_ready_i) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut) else $error("valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("accept while result pending");
  a_div_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.div_start |=> state_q == StDiv) else $error("divider not started");
`endif
endmodule

// File: rtl/core/m64c_dpath.sv
// ----------------------------------------------------------------------------
// m64c_dpath
// Architectural state, decode, ALU, multiplier and serial divider.
// ----------------------------------------------------------------------------
module m64c_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  m64c_pkg::ctrl_t   ctrl_i,
  input  m64c_pkg::item_t   item_i,
  output m64c_pkg::stat_t   stat_o,
  output m64c_pkg::result_t res_o
);
  localparam int unsigned RegAw = $clog2(m64c_pkg::NumRegs);
  localparam int unsigned CntW  = $clog2(m64c_pkg::DivBits);

  m64c_pkg::item_t item_q;
  logic [RegAw-1:0] wcount_q; // reset sweep of the register files
  logic             boot_q;
  logic [63:0] hi_q, lo_q;
  logic [31:0] pc_q, dtgt_q;
  logic        dval_q;
  logic        lval_q;
  logic [2:0]  lkind_q;
  logic [4:0]  lreg_q;
  m64c_pkg::result_t res_q;

  // Divider.
  logic [31:0] dq_q, dr_q, dd_q;
  logic [CntW-1:0] dcnt_q;

  // Register-file ports.
  logic        gwe, cwe;
  logic [4:0]  gwa, cwa;
  logic [63:0] gwd, cwd;
  logic [63:0] ra, rb, c0a, c0b;

  logic [31:0] ins;
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [63:0] a, b, imm, simm, c0;
  logic [31:0] boff, pcx, pc4, ea;

  assign ins  = item_q.instr_word;
  assign op   = ins[31:26];
  assign fn   = ins[5:0];
  assign rs   = ins[25:21];
  assign rt   = ins[20:16];
  assign rd   = ins[15:11];
  assign sa   = ins[10:6];
  assign imm  = {48'd0, ins[15:0]};
  assign simm = {{48{ins[15]}}, ins[15:0]};
  assign boff = {{14{ins[15]}}, ins[15:0], 2'b00};
  assign a    = (rs == 5'd0) ? 64'd0 : ra;
  assign b    = (rt == 5'd0) ? 64'd0 : rb;
  assign c0   = c0a;
  assign pcx  = dval_q ? dtgt_q - 32'd4 : pc_q;
  assign pc4  = pcx + 32'd4;
  assign ea   = a[31:0] + simm[31:0];

  assign stat_o.is_div   = !item_q.cmd && op == 6'd0 && fn == 6'd27 && b[31:0] != 32'd0;
  assign stat_o.div_last = (dcnt_q == CntW'(m64c_pkg::DivBits - 1));
  assign res_o = res_q;

  m64c_ram #(.Width(64), .Depth(m64c_pkg::NumRegs)) u_gpr (
    .clk_i, .we_i(gwe), .waddr_i(gwa), .wdata_i(gwd),
    .raddr_a_i(item_q.instr_word[25:21]), .raddr_b_i(item_q.instr_word[20:16]),
    .rdata_a_o(ra), .rdata_b_o(rb));

  m64c_ram #(.Width(64), .Depth(m64c_pkg::NumRegs)) u_cop0 (
    .clk_i, .we_i(cwe), .waddr_i(cwa), .wdata_i(cwd),
    .raddr_a_i(item_q.instr_word[15:11]), .raddr_b_i(item_q.instr_word[15:11]),
    .rdata_a_o(c0a), .rdata_b_o(c0b));

  // 32x32 products serve both mult (signed) and multu (unsigned).
  logic [63:0] prod;
  logic        sgn_mul;
  assign sgn_mul = (fn == 6'd24);
  assign prod = sgn_mul ? 64'($signed(a[31:0]) * $signed(b[31:0])) : a[31:0] * b[31:0];

  logic        wr_en;
  logic [4:0]  wr_reg;
  logic [63:0] wr_val;
  logic        c0_en;
  logic        hi_en, lo_en;
  logic [63:0] hi_d, lo_d;
  logic        dval_d;
  logic [31:0] dtgt_d, pc_d;
  logic        lval_d;
  logic [2:0]  lkind_d;
  m64c_pkg::result_t r;
  logic [63:0] ldv;
  logic        cond, likely, isbr, ge;
  logic [31:0] sh32;
  logic [63:0] sra64;

  always_comb begin
    wr_en = 1'b0; wr_reg = rd; wr_val = '0; c0_en = 1'b0;
    hi_en = 1'b0; lo_en = 1'b0; hi_d = a; lo_d = a;
    dval_d = 1'b0; dtgt_d = dtgt_q; pc_d = pc4;
    lval_d = 1'b0; lkind_d = lkind_q;
    r = '0; ldv = '0; cond = 1'b0; likely = 1'b0; isbr = 1'b0;
    ge = !a[63]; sh32 = '0; sra64 = '0;
    if (item_q.cmd) begin
      pc_d = pc_q; dval_d = dval_q; lval_d = 1'b0;
      case (lkind_q)
        3'd0: ldv = {{56{item_q.load_data[7]}}, item_q.load_data[7:0]};
        3'd1: ldv = {{48{item_q.load_data[15]}}, item_q.load_data[15:0]};
        3'd2: ldv = m64c_pkg::sx32(item_q.load_data[31:0]);
        3'd3: ldv = {56'd0, item_q.load_data[7:0]};
        3'd4: ldv = {48'd0, item_q.load_data[15:0]};
        3'd5: ldv = {32'd0, item_q.load_data[31:0]};
        default: ldv = item_q.load_data;
      endcase
      wr_en = lval_q; wr_reg = lreg_q; wr_val = ldv;
    end else begin
      case (op)
        6'd0: begin
          wr_en = 1'b1;
          case (fn)
            6'd0: begin sh32 = b[31:0] << sa; wr_val = m64c_pkg::sx32(sh32); end
            6'd2: begin sh32 = b[31:0] >> sa; wr_val = m64c_pkg::sx32(sh32); end
            6'd3: begin
              sh32 = 32'($signed(b[31:0]) >>> sa); wr_val = m64c_pkg::sx32(sh32);
            end
            6'd4: begin sh32 = b[31:0] << a[4:0]; wr_val = m64c_pkg::sx32(sh32); end
            6'd6: begin sh32 = b[31:0] >> a[4:0]; wr_val = m64c_pkg::sx32(sh32); end
            6'd8, 6'd9: begin
              wr_en = 1'b0;
              if (a[1:0] != 2'b00) begin
                r.fault = m64c_pkg::FaultAlign;
              end else begin
                dval_d = 1'b1; dtgt_d = a[31:0];
                wr_en = (fn == 6'd9); wr_val = m64c_pkg::sx32(pcx + 32'd8);
              end
            end
            6'd16: wr_val = hi_q;
            6'd17: begin wr_en = 1'b0; hi_en = 1'b1; end
            6'd18: wr_val = lo_q;
            6'd19: begin wr_en = 1'b0; lo_en = 1'b1; end
            6'd24, 6'd25: begin
              wr_en = 1'b0; hi_en = 1'b1; lo_en = 1'b1;
              hi_d = m64c_pkg::sx32(prod[63:32]); lo_d = m64c_pkg::sx32(prod[31:0]);
            end
            6'd27: begin
              wr_en = 1'b0; hi_en = 1'b1; lo_en = 1'b1;
              hi_d = m64c_pkg::sx32(a[31:0]); lo_d = '1;
            end
            6'd32, 6'd33: wr_val = m64c_pkg::sx32(a[31:0] + b[31:0]);
            6'd35: wr_val = m64c_pkg::sx32(a[31:0] - b[31:0]);
            6'd36: wr_val = a & b;
            6'd37: wr_val = a | b;
            6'd38: wr_val = a ^ b;
            6'd42: wr_val = {63'd0, $signed(a) < $signed(b)};
            6'd43: wr_val = {63'd0, a < b};
            6'd63: begin
              sra64 = $signed(b) >>> ({1'b0, sa} + 6'd32); wr_val = sra64;
            end
            default: begin wr_en = 1'b0; r.fault = m64c_pkg::FaultOpcode; end
          endcase
        end
        6'd1: begin
          isbr = 1'b1; cond = ge;
          if (rt == 5'd1) begin
            likely = 1'b0;
          end else if (rt == 5'd3) begin
            likely = 1'b1;
          end else if (rt == 5'd17) begin
            wr_en = 1'b1; wr_reg = 5'd31; wr_val = m64c_pkg::sx32(pcx + 32'd8);
          end else begin
            isbr = 1'b0; r.fault = m64c_pkg::FaultOpcode;
          end
        end
        6'd2, 6'd3: begin
          dval_d = 1'b1;
          dtgt_d = {pc4[31:28], ins[25:0], 2'b00};
          wr_en = (op == 6'd3); wr_reg = 5'd31; wr_val = m64c_pkg::sx32(pcx + 32'd8);
        end
        6'd4: begin isbr = 1'b1; cond = (a == b); end
        6'd5: begin isbr = 1'b1; cond = (a != b); end
        6'd6: begin isbr = 1'b1; cond = ($signed(a) <= 0); end
        6'd7: begin isbr = 1'b1; cond = ($signed(a) > 0); end
        6'd20: begin isbr = 1'b1; likely = 1'b1; cond = (a == b); end
        6'd21: begin isbr = 1'b1; likely = 1'b1; cond = (a != b); end
        6'd22: begin isbr = 1'b1; likely = 1'b1; cond = ($signed(a) <= 0); end
        6'd8, 6'd9: begin
          wr_en = 1'b1; wr_reg = rt; wr_val = m64c_pkg::sx32(a[31:0] + simm[31:0]);
        end
        6'd10: begin wr_en = 1'b1; wr_reg = rt; wr_val = {63'd0, $signed(a) < $signed(simm)}; end
        6'd11: begin wr_en = 1'b1; wr_reg = rt; wr_val = {63'd0, a < simm}; end
        6'd12: begin wr_en = 1'b1; wr_reg = rt; wr_val = a & imm; end
        6'd13: begin wr_en = 1'b1; wr_reg = rt; wr_val = a | imm; end
        6'd14: begin wr_en = 1'b1; wr_reg = rt; wr_val = a ^ imm; end
        6'd15: begin
          wr_en = 1'b1; wr_reg = rt; wr_val = m64c_pkg::sx32({ins[15:0], 16'd0});
        end
        6'd16: begin
          if (rs == 5'd0) begin
            wr_en = 1'b1; wr_reg = rt; wr_val = m64c_pkg::sx32(c0[31:0]);
          end else if (rs == 5'd4) begin
            c0_en = 1'b1;
          end else if (rs != 5'h10) begin
            r.fault = m64c_pkg::FaultOpcode;
          end
        end
        6'd17, 6'd47: ;
        6'd32, 6'd33, 6'd35, 6'd36, 6'd37, 6'd39, 6'd55: begin
          lval_d = 1'b1; r.mem_request = m64c_pkg::MemLoad; r.mem_addr = ea;
          case (op)
            6'd32: begin lkind_d = 3'd0; r.mem_size = 2'd0; end
            6'd33: begin lkind_d = 3'd1; r.mem_size = 2'd1; end
            6'd35: begin lkind_d = 3'd2; r.mem_size = 2'd2; end
            6'd36: begin lkind_d = 3'd3; r.mem_size = 2'd0; end
            6'd37: begin lkind_d = 3'd4; r.mem_size = 2'd1; end
            6'd39: begin lkind_d = 3'd5; r.mem_size = 2'd2; end
            default: begin lkind_d = 3'd6; r.mem_size = 2'd3; end
          endcase
        end
        6'd40, 6'd41, 6'd43, 6'd63: begin
          r.mem_request = m64c_pkg::MemStore; r.mem_addr = ea; r.store_data = b;
          case (op)
            6'd40: r.mem_size = 2'd0;
            6'd41: r.mem_size = 2'd1;
            6'd43: r.mem_size = 2'd2;
            default: r.mem_size = 2'd3;
          endcase
        end
        default: r.fault = m64c_pkg::FaultOpcode;
      endcase
      if (isbr) begin
        if (cond) begin
          dval_d = 1'b1; dtgt_d = pcx + boff + 32'd4;
        end else if (likely) begin
          pc_d = pcx + 32'd8;
        end
      end
    end
    r.fetch_pc = pc_d;
  end

  // Register-file write selection: reset sweep or execute.
  always_comb begin
    gwe = 1'b0; gwa = wr_reg; gwd = wr_val;
    cwe = 1'b0; cwa = rd; cwd = b;
    if (!boot_q) begin
      gwe = 1'b1; gwa = wcount_q; cwe = 1'b1; cwa = wcount_q; cwd = '0;
      case (wcount_q)
        5'd11: gwd = m64c_pkg::BootR11;
        5'd20: gwd = m64c_pkg::BootR20;
        5'd22: gwd = m64c_pkg::BootR22;
        5'd29: gwd = m64c_pkg::BootR29;
        default: gwd = '0;
      endcase
    end else if (ctrl_i.execute) begin
      gwe = wr_en && (wr_reg != 5'd0);
      cwe = c0_en;
    end
  end

  logic [32:0] dtrial;
  assign dtrial = {dr_q, dd_q[31]} - {1'b0, b[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q <= '0; boot_q <= 1'b0;
      hi_q <= '0; lo_q <= '0; pc_q <= m64c_pkg::BootPc;
      dval_q <= 1'b0; dtgt_q <= '0; lval_q <= 1'b0; lkind_q <= '0; lreg_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (!boot_q) begin
        wcount_q <= wcount_q + 5'd1;
        if (wcount_q == 5'(m64c_pkg::NumRegs - 1)) boot_q <= 1'b1;
      end
      if (ctrl_i.execute) begin
        if (hi_en) hi_q <= hi_d;
        if (lo_en) lo_q <= lo_d;
        pc_q <= pc_d; dval_q <= dval_d; dtgt_q <= dtgt_d;
        lval_q <= lval_d; lkind_q <= lkind_d;
        if (lval_d) lreg_q <= rt;
      end
      if (ctrl_i.div_start) begin
        dcnt_q <= '0;
      end else if (ctrl_i.div_step) begin
        dcnt_q <= dcnt_q + CntW'(1);
      end
      if (ctrl_i.div_done) begin
        hi_q <= m64c_pkg::sx32(dr_q); lo_q <= m64c_pkg::sx32(dq_q);
        pc_q <= pc_d; dval_q <= dval_d; dtgt_q <= dtgt_d; lval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) item_q <= item_i;
    if (ctrl_i.div_start) begin
      dd_q <= a[31:0]; dr_q <= '0; dq_q <= '0;
    end else if (ctrl_i.div_step) begin
      dd_q <= dd_q << 1;
      if (!dtrial[32]) begin
        dr_q <= dtrial[31:0]; dq_q <= {dq_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dd_q[31]}; dq_q <= {dq_q[30:0], 1'b0};
      end
    end
    if (ctrl_i.res_load) res_q <= r;
  end

  logic unused;
  assign unused = ^{c0b, ctrl_i.read_regs};

`ifndef ASSERT_OFF
  a_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (boot_q && gwe) |-> gwa != 5'd0) else $error("write to r0");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_done |-> $past(dcnt_q) == CntW'(m64c_pkg::DivBits - 1))
    else $error("divider step count");
  a_req_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.mem_request == m64c_pkg::MemNone && ctrl_i.res_load == 1'b0 && boot_q)
      |-> 1'b1) else $error("unreachable");
`endif
endmodule

// File: rtl/core/mips64_integer_core_step.sv
// ----------------------------------------------------------------------------
// mips64_integer_core_step
// MIPS64 integer subset executed one fetched word per transaction.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_if    in   cmd, instr_word, load_data
// out_if   out  fetch_pc, mem_request, mem_size, mem_addr, store_data, fault
//
// A transaction goes through accept, register read, execute and result;
// divu with a nonzero divisor adds the steps of the bit-serial divider and
// its commit. After reset a pass over every register initializes the register
// files; no transaction is accepted until it is over. The result stays in its
// register until taken, and the next transaction is accepted once it is.
module mips64_integer_core_step (
  input  logic clk_i,
  input  logic rst_ni,
  m64c_stream_if.sink   in_if,
  m64c_stream_if.source out_if
);
  m64c_pkg::ctrl_t ctrl;
  m64c_pkg::stat_t stat;
  logic            rdy;
  logic            boot_done_q;
  logic [5:0]      boot_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_cnt_q <= '0; boot_done_q <= 1'b0;
    end else if (!boot_done_q) begin
      boot_cnt_q <= boot_cnt_q + 6'd1;
      if (boot_cnt_q == 6'(m64c_pkg::NumRegs)) boot_done_q <= 1'b1;
    end
  end

  assign in_if.ready = rdy && boot_done_q;

  m64c_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid && boot_done_q), .in_ready_o(rdy),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .ctrl_o(ctrl));

  m64c_dpath u_dpath (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .item_i(in_if.payload),
    .stat_o(stat), .res_o(out_if.payload));
endmodule

// File: dv/m64c_isa_pkg.sv
// ----------------------------------------------------------------------------
// m64c_isa_pkg
// Instruction field codes shared by the core step stimulus and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package m64c_isa_pkg;

  typedef enum logic [5:0] {
    OpSpecial = 6'd0,  OpRegimm = 6'd1,  OpJ     = 6'd2,  OpJal    = 6'd3,
    OpBeq     = 6'd4,  OpBne    = 6'd5,  OpBlez  = 6'd6,  OpBgtz   = 6'd7,
    OpAddi    = 6'd8,  OpAddiu  = 6'd9,  OpSlti  = 6'd10, OpSltiu  = 6'd11,
    OpAndi    = 6'd12, OpOri    = 6'd13, OpXori  = 6'd14, OpLui    = 6'd15,
    OpCop0    = 6'd16, OpCop1   = 6'd17, OpBeql  = 6'd20, OpBnel   = 6'd21,
    OpBlezl   = 6'd22, OpLb     = 6'd32, OpLh    = 6'd33, OpLw     = 6'd35,
    OpLbu     = 6'd36, OpLhu    = 6'd37, OpLwu   = 6'd39, OpSb     = 6'd40,
    OpSh      = 6'd41, OpSw     = 6'd43, OpCache = 6'd47, OpLd     = 6'd55,
    OpSd      = 6'd63
  } opcode_e;

  typedef enum logic [5:0] {
    FnSll   = 6'd0,  FnSrl   = 6'd2,  FnSra   = 6'd3,  FnSllv  = 6'd4,
    FnSrlv  = 6'd6,  FnJr    = 6'd8,  FnJalr  = 6'd9,  FnMfhi  = 6'd16,
    FnMthi  = 6'd17, FnMflo  = 6'd18, FnMtlo  = 6'd19, FnMult  = 6'd24,
    FnMultu = 6'd25, FnDivu  = 6'd27, FnAdd   = 6'd32, FnAddu  = 6'd33,
    FnSubu  = 6'd35, FnAnd   = 6'd36, FnOr    = 6'd37, FnXor   = 6'd38,
    FnSlt   = 6'd42, FnSltu  = 6'd43, FnDsra32 = 6'd63
  } funct_e;

  localparam logic [4:0] RiBgez   = 5'd1;
  localparam logic [4:0] RiBgezl  = 5'd3;
  localparam logic [4:0] RiBgezal = 5'd17;

  localparam logic [4:0] CpMfc0  = 5'd0;
  localparam logic [4:0] CpMtc0  = 5'd4;
  localparam logic [4:0] CpGroup = 5'd16;

  // An opcode with no meaning in this subset.
  localparam logic [5:0] OpUnknown = 6'd59;

  typedef enum logic [2:0] {
    LdByte, LdHalf, LdWord, LdByteU, LdHalfU, LdWordU, LdDouble
  } load_kind_e;

endpackage

// File: dv/m64c_core_checker.sv
// ----------------------------------------------------------------------------
// m64c_core_checker
// Watches both channels of the core step block, predicts each result from an
// architectural model of the integer subset, and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module m64c_core_checker
  import m64c_pkg::*;
  import m64c_isa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  m64c_stream_if in_mon,
  m64c_stream_if out_mon,
  output int    errors_o,
  output int    pending_o
);

  logic [63:0] gpr [32];
  logic [63:0] cp0 [32];
  logic [63:0] hi_q, lo_q;
  logic [31:0] pc_q, exec_pc, branch_tgt;
  logic        branch_pend;
  logic        load_pend;
  load_kind_e  load_kind;
  logic [4:0]  load_dst;
  result_t     expected_q[$];

  function automatic logic [63:0] sext32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function void reg_write(input logic [4:0] r, input logic [63:0] v);
    if (r != 5'd0) gpr[r] = v;
  endfunction

  function void take_branch(input logic [31:0] off, input logic cond, input logic likely);
    if (cond) begin
      branch_pend = 1'b1;
      branch_tgt  = exec_pc + off + 32'd4;
    end else if (likely) begin
      exec_pc = exec_pc + 32'd4;
    end
  endfunction

  function void arch_reset();
    for (int i = 0; i < 32; i++) begin
      gpr[i] = '0;
      cp0[i] = '0;
    end
    gpr[11] = 64'hFFFF_FFFF_A400_0040;
    gpr[20] = 64'd1;
    gpr[22] = 64'h3F;
    gpr[29] = 64'hFFFF_FFFF_A400_1FF0;
    hi_q = '0;
    lo_q = '0;
    pc_q = 32'hA400_0040;
    branch_pend = 1'b0;
    branch_tgt = '0;
    load_pend = 1'b0;
    load_kind = LdByte;
    load_dst = '0;
  endfunction

  function result_t execute_item(input item_t it);
    result_t     r;
    logic [31:0] ins, boff;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [63:0] a, b, simm, zimm, p, d;
    logic [31:0] x, y;
    r = '0;
    if (it.cmd) begin
      if (load_pend) begin
        d = it.load_data;
        case (load_kind)
          LdByte:  d = {{56{d[7]}}, d[7:0]};
          LdHalf:  d = {{48{d[15]}}, d[15:0]};
          LdWord:  d = sext32(d[31:0]);
          LdByteU: d = {56'd0, d[7:0]};
          LdHalfU: d = {48'd0, d[15:0]};
          LdWordU: d = {32'd0, d[31:0]};
          default: ;
        endcase
        reg_write(load_dst, d);
        load_pend = 1'b0;
      end
    end else begin
      ins = it.instr_word;
      op = ins[31:26]; fn = ins[5:0];
      rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; sa = ins[10:6];
      zimm = {48'd0, ins[15:0]};
      simm = {{48{ins[15]}}, ins[15:0]};
      a = gpr[rs]; b = gpr[rt];
      boff = {simm[29:0], 2'b00};
      exec_pc = pc_q;
      load_pend = 1'b0;
      if (branch_pend) begin
        exec_pc = branch_tgt - 32'd4;
        branch_pend = 1'b0;
      end
      case (op)
        OpSpecial: begin
          case (fn)
            FnSll:  reg_write(rd, sext32(b[31:0] << sa));
            FnSrl:  reg_write(rd, sext32(b[31:0] >> sa));
            FnSra:  reg_write(rd, sext32($signed(b[31:0]) >>> sa));
            FnSllv: reg_write(rd, sext32(b[31:0] << a[4:0]));
            FnSrlv: reg_write(rd, sext32(b[31:0] >> a[4:0]));
            FnJr, FnJalr: begin
              if (a[1:0] != 2'b00) begin
                r.fault = FaultAlign;
              end else begin
                branch_pend = 1'b1;
                branch_tgt = a[31:0];
                if (fn == FnJalr) reg_write(rd, sext32(exec_pc + 32'd8));
              end
            end
            FnMfhi: reg_write(rd, hi_q);
            FnMthi: hi_q = a;
            FnMflo: reg_write(rd, lo_q);
            FnMtlo: lo_q = a;
            FnMult, FnMultu: begin
              if (fn == FnMult) p = $signed(sext32(a[31:0])) * $signed(sext32(b[31:0]));
              else p = {32'd0, a[31:0]} * {32'd0, b[31:0]};
              hi_q = sext32(p[63:32]);
              lo_q = sext32(p[31:0]);
            end
            FnDivu: begin
              x = a[31:0]; y = b[31:0];
              if (y == 32'd0) begin
                hi_q = sext32(x);
                lo_q = '1;
              end else begin
                hi_q = sext32(x % y);
                lo_q = sext32(x / y);
              end
            end
            FnAdd, FnAddu: reg_write(rd, sext32(a[31:0] + b[31:0]));
            FnSubu: reg_write(rd, sext32(a[31:0] - b[31:0]));
            FnAnd:  reg_write(rd, a & b);
            FnOr:   reg_write(rd, a | b);
            FnXor:  reg_write(rd, a ^ b);
            FnSlt:  reg_write(rd, {63'd0, $signed(a) < $signed(b)});
            FnSltu: reg_write(rd, {63'd0, a < b});
            FnDsra32: reg_write(rd, $signed(b) >>> (sa + 6'd32));
            default: r.fault = FaultOpcode;
          endcase
        end
        OpRegimm: begin
          if (rt == RiBgez) take_branch(boff, !a[63], 1'b0);
          else if (rt == RiBgezl) take_branch(boff, !a[63], 1'b1);
          else if (rt == RiBgezal) begin
            take_branch(boff, !a[63], 1'b0);
            reg_write(5'd31, sext32(exec_pc + 32'd8));
          end else r.fault = FaultOpcode;
        end
        OpJ, OpJal: begin
          branch_pend = 1'b1;
          x = exec_pc + 32'd4;
          branch_tgt = {x[31:28], ins[25:0], 2'b00};
          if (op == OpJal) reg_write(5'd31, sext32(exec_pc + 32'd8));
        end
        OpBeq:   take_branch(boff, a == b, 1'b0);
        OpBne:   take_branch(boff, a != b, 1'b0);
        OpBlez:  take_branch(boff, $signed(a) <= 0, 1'b0);
        OpBgtz:  take_branch(boff, $signed(a) > 0, 1'b0);
        OpAddi, OpAddiu: reg_write(rt, sext32(a[31:0] + simm[31:0]));
        OpSlti:  reg_write(rt, {63'd0, $signed(a) < $signed(simm)});
        OpSltiu: reg_write(rt, {63'd0, a < simm});
        OpAndi:  reg_write(rt, a & zimm);
        OpOri:   reg_write(rt, a | zimm);
        OpXori:  reg_write(rt, a ^ zimm);
        OpLui:   reg_write(rt, sext32({ins[15:0], 16'd0}));
        OpCop0: begin
          if (rs == CpMfc0) reg_write(rt, sext32(cp0[rd][31:0]));
          else if (rs == CpMtc0) cp0[rd] = b;
          else if (rs != CpGroup) r.fault = FaultOpcode;
        end
        OpCop1, OpCache: ;
        OpBeql:  take_branch(boff, a == b, 1'b1);
        OpBnel:  take_branch(boff, a != b, 1'b1);
        OpBlezl: take_branch(boff, $signed(a) <= 0, 1'b1);
        OpLb, OpLh, OpLw, OpLbu, OpLhu, OpLwu, OpLd: begin
          case (op)
            OpLb:    begin load_kind = LdByte;   r.mem_size = 2'd0; end
            OpLh:    begin load_kind = LdHalf;   r.mem_size = 2'd1; end
            OpLw:    begin load_kind = LdWord;   r.mem_size = 2'd2; end
            OpLbu:   begin load_kind = LdByteU;  r.mem_size = 2'd0; end
            OpLhu:   begin load_kind = LdHalfU;  r.mem_size = 2'd1; end
            OpLwu:   begin load_kind = LdWordU;  r.mem_size = 2'd2; end
            default: begin load_kind = LdDouble; r.mem_size = 2'd3; end
          endcase
          load_pend = 1'b1;
          load_dst = rt;
          r.mem_request = MemLoad;
          r.mem_addr = a[31:0] + simm[31:0];
        end
        OpSb, OpSh, OpSw, OpSd: begin
          r.mem_request = MemStore;
          r.mem_size = (op == OpSb) ? 2'd0 : (op == OpSh) ? 2'd1 : (op == OpSw) ? 2'd2 : 2'd3;
          r.mem_addr = a[31:0] + simm[31:0];
          r.store_data = b;
        end
        default: r.fault = FaultOpcode;
      endcase
      pc_q = exec_pc + 32'd4;
    end
    r.fetch_pc = pc_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp;
    if (!rst_ni) begin
      arch_reset();
      expected_q.delete();
      errors_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) expected_q.push_back(execute_item(in_mon.payload));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          exp = expected_q.pop_front();
          if (got !== exp) begin
            errors_o <= errors_o + 1;
            if (got.fetch_pc !== exp.fetch_pc)
              $display("%0t: fetch_pc expected %h actual %h", $time, exp.fetch_pc, got.fetch_pc);
            if (got.mem_request !== exp.mem_request)
              $display("%0t: mem_request expected %0d actual %0d", $time,
                       exp.mem_request, got.mem_request);
            if (got.mem_size !== exp.mem_size)
              $display("%0t: mem_size expected %0d actual %0d", $time, exp.mem_size, got.mem_size);
            if (got.mem_addr !== exp.mem_addr)
              $display("%0t: mem_addr expected %h actual %h", $time, exp.mem_addr, got.mem_addr);
            if (got.store_data !== exp.store_data)
              $display("%0t: store_data expected %h actual %h", $time,
                       exp.store_data, got.store_data);
            if (got.fault !== exp.fault)
              $display("%0t: fault expected %0d actual %0d", $time, exp.fault, got.fault);
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the core step testbench: drives directed and random instruction
// streams with load data returns, stalls both channels at random, and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import m64c_pkg::*;
  import m64c_isa_pkg::*;

  localparam int CycleLimit = 1_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, cycles, ready_hold, stretch;

  m64c_stream_if #(.payload_t(item_t))   in_ch ();
  m64c_stream_if #(.payload_t(result_t)) out_ch ();

  mips64_integer_core_step dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  m64c_core_checker checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (stretch > 0) return 0;
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      ready_hold <= 0;
      stretch <= 0;
    end else begin
      stretch <= (stretch > 0) ? stretch - 1 :
                 ($urandom_range(0, 499) == 0) ? 300 : 0;
      if (ready_hold > 0) begin
        out_ch.ready <= 1'b0;
        ready_hold <= ready_hold - 1;
      end else begin
        out_ch.ready <= 1'b1;
        ready_hold <= gap_len();
      end
    end
  end

  task automatic send(input logic cmd, input logic [31:0] word, input logic [63:0] data);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{cmd: cmd, instr_word: word, load_data: data};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic exec(input logic [31:0] word);
    send(1'b0, word, {$urandom, $urandom});
  endtask

  task automatic give(input logic [63:0] data);
    send(1'b1, $urandom, data);
  endtask

  function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sa,
                                        input funct_e fn);
    return {OpSpecial, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_word();
    funct_e  fns[23] = '{FnSll, FnSrl, FnSra, FnSllv, FnSrlv, FnJr, FnJalr, FnMfhi, FnMthi,
                        FnMflo, FnMtlo, FnMult, FnMultu, FnDivu, FnAdd, FnAddu, FnSubu,
                        FnAnd, FnOr, FnXor, FnSlt, FnSltu, FnDsra32};
    opcode_e ops[32] = '{OpJ, OpJal, OpBeq, OpBne, OpBlez, OpBgtz, OpAddi, OpAddiu,
                        OpSlti, OpSltiu, OpAndi, OpOri, OpXori, OpLui, OpCop0, OpCop1,
                        OpBeql, OpBnel, OpBlezl, OpLb, OpLh, OpLw, OpLbu, OpLhu, OpLwu,
                        OpSb, OpSh, OpSw, OpCache, OpLd, OpSd, OpRegimm};
    logic [4:0] ri[3] = '{RiBgez, RiBgezl, RiBgezal};
    logic [4:0] cp[3] = '{CpMfc0, CpMtc0, CpGroup};
    opcode_e op;
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return $urandom;
    if (k < 45)
      return rtype(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), fns[$urandom_range(0, 22)]);
    op = ops[$urandom_range(0, 31)];
    if (op == OpRegimm)
      return itype(op, pick_reg(), ri[$urandom_range(0, 2)], pick_imm());
    if (op == OpCop0)
      return {op, cp[$urandom_range(0, 2)], pick_reg(), 5'($urandom), 11'($urandom)};
    if (op == OpJ || op == OpJal) return {op, 26'($urandom)};
    return itype(op, pick_reg(), pick_reg(), pick_imm());
  endfunction

  initial begin
    logic [31:0] w;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    exec(itype(OpLui, 5'd1, 5'd1, 16'h8000));
    exec(itype(OpOri, 5'd1, 5'd1, 16'hFFFF));
    exec(itype(OpAddiu, 5'd0, 5'd2, 16'hFFFF));
    exec(itype(OpAddiu, 5'd0, 5'd0, 16'h1234));
    exec(rtype(5'd1, 5'd2, 5'd3, 5'd31, FnSll));
    exec(rtype(5'd0, 5'd1, 5'd4, 5'd31, FnSra));
    exec(rtype(5'd0, 5'd2, 5'd5, 5'd31, FnDsra32));
    exec(rtype(5'd1, 5'd2, 5'd0, 5'd0, FnMult));
    exec(rtype(5'd1, 5'd2, 5'd0, 5'd0, FnMultu));
    exec(rtype(5'd1, 5'd0, 5'd0, 5'd0, FnDivu));
    exec(rtype(5'd2, 5'd22, 5'd0, 5'd0, FnDivu));
    exec(rtype(5'd0, 5'd0, 5'd6, 5'd0, FnMfhi));
    exec({OpCop0, CpMtc0, 5'd2, 5'd12, 11'd0});
    exec({OpCop0, CpMfc0, 5'd7, 5'd12, 11'd0});
    exec({OpCop0, CpGroup, 5'd0, 5'd0, 11'd0});
    exec(itype(OpCop1, 5'd3, 5'd3, 16'h0));
    exec(itype(OpCache, 5'd3, 5'd3, 16'h0));
    exec({OpUnknown, 26'h155_5555});
    exec(rtype(5'd2, 5'd0, 5'd31, 5'd0, FnJalr));
    exec(rtype(5'd11, 5'd0, 5'd9, 5'd0, FnJalr));
    exec(itype(OpBeql, 5'd0, 5'd20, 16'h0010));
    exec(itype(OpRegimm, 5'd2, RiBgezal, 16'hFFF0));
    exec(itype(OpLb, 5'd29, 5'd8, 16'h8000));
    give(64'hFFFF_FFFF_FFFF_FF80);
    exec(itype(OpLd, 5'd29, 5'd9, 16'h7FFF));
    give(64'h8000_0000_0000_0001);
    give(64'h1);
    exec(itype(OpLw, 5'd0, 5'd10, 16'h0));
    exec(itype(OpSd, 5'd2, 5'd9, 16'hFFFF));

    for (int n = 0; n < 800; n++) begin
      w = random_word();
      exec(w);
      if (w[31:26] inside {OpLb, OpLh, OpLw, OpLbu, OpLhu, OpLwu, OpLd}) begin
        if ($urandom_range(0, 9) != 0) give({$urandom, $urandom});
      end else if ($urandom_range(0, 29) == 0) begin
        give({$urandom, $urandom});
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/m64c_pkg.sv
rtl/core/m64c_stream_if.sv
rtl/core/m64c_ram.sv
rtl/core/m64c_ctrl.sv
rtl/core/m64c_dpath.sv
rtl/core/mips64_integer_core_step.sv
dv/m64c_isa_pkg.sv
dv/m64c_core_checker.sv
dv/tb.sv
